// ===== hdl/banded_triangular_solve_defines.svh =====
// Assertion macros shared by the solver RTL.
// No dependencies.
`ifndef BANDED_TRIANGULAR_SOLVE_DEFINES_SVH
`define BANDED_TRIANGULAR_SOLVE_DEFINES_SVH
// implication checked every edge outside reset
`define BTS_ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define BTS_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/bts_pkg.sv =====
// Package for the banded triangular solver: payload types, opcodes, states.
// No dependencies.
`default_nettype none
package bts_pkg;
   localparam int MAX_N    = 64;
   localparam int MAX_BAND = 16;

   localparam logic [1:0] OP_BAND  = 2'd0;
   localparam logic [1:0] OP_RHS   = 2'd1;
   localparam logic [1:0] OP_SOLVE = 2'd2;

   localparam logic [2:0] REG_SIZE  = 3'd0;
   localparam logic [2:0] REG_BAND  = 3'd1;
   localparam logic [2:0] REG_UPPER = 3'd2;
   localparam logic [2:0] REG_TRANS = 3'd3;
   localparam logic [2:0] REG_UNIT  = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         column;
      logic [4:0]         band_pos;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [5:0]         index;
      logic signed [31:0] solution;
      logic               last;
      logic               div_zero;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW, ST_RHS, ST_TERM, ST_MUL, ST_DIAG, ST_START, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] dividend;
      logic signed [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== hdl/bts_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/bts_div.sv =====
// Restoring divider: 64-bit signed dividend by 32-bit divisor, saturated.
// Depends on bts_pkg.
`default_nettype none
module bts_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bts_pkg::div_req_type req,
   output bts_pkg::div_rsp_type      rsp
);
   import bts_pkg::*;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [64:0] shifted, trial;
   logic [64:0] qs;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      trial = shifted - {33'd0, dvs_ff};
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
         dvs_in = req.divisor[31] ? 32'(-req.divisor) : 32'(req.divisor);
         neg_in = req.dividend[63] ^ req.divisor[31];
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in;
   end

   always_comb begin
      qs = neg_ff ? 65'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
      rsp.done = done_ff;
      if (!qs[64] && qs[63:31] != '0) rsp.quotient = 32'h7FFF_FFFF;
      else if (qs[64] && qs[63:31] != {33{1'b1}}) rsp.quotient = 32'h8000_0000;
      else rsp.quotient = qs[31:0];
   end
endmodule
`default_nettype wire

// ===== hdl/banded_triangular_solve.sv =====
// Banded triangular solver top level: CSRs, band and vector RAMs, sequencer.
// Depends on bts_pkg, bts_ram, bts_div and banded_triangular_solve_defines.svh.
//
// Usage:
//  - req_* (valid/ready) carries load and start transfers. Loads can
//    follow back to back while the sequencer is idle.
//  - A start transfer drops req_ready until the last solution has been
//    placed in the rsp_* register; loads may follow while it waits there.
//  - Per row: rhs read, one band and one vector read plus a multiply
//    per term, diagonal read, output step, with terms <= k.
//    A non-unit, nonzero diagonal adds a wait on the 64-step serial divider.
//  - A result is valid the cycle after its row's output step; a solve of
//    n rows takes the sum of its row times.
//  - rsp_* is one output register; a stalled receiver holds the sequencer
//    in its output step, adding the stall cycles to that row.
//  - Reset sets n=1, k=0 and flags 0; RAM contents are undefined until
//    loaded. No clearing pass.
//  - csr_* writes only while idle with no result pending.
`default_nettype none
`include "banded_triangular_solve_defines.svh"
module banded_triangular_solve (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bts_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [6:0]       csr_data
);
   import bts_pkg::*;
   localparam int NW = $clog2(MAX_N);
   localparam int KW = $clog2(MAX_BAND + 1);
   localparam int BD = (MAX_BAND + 1) * MAX_N;
   localparam int BW = $clog2(BD);
   localparam int CW = $clog2(MAX_N + 1);
   localparam logic signed [71:0] ACC_MAX = 72'sd2147483647;
   localparam logic signed [71:0] ACC_MIN = -72'sd2147483648;

   // configuration registers
   logic [6:0] size_ff;
   logic [4:0] bandw_ff;
   logic upper_ff, trans_ff, unit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 7'd1; bandw_ff <= '0;
         upper_ff <= 1'b0; trans_ff <= 1'b0; unit_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SIZE:  size_ff  <= csr_data;
            REG_BAND:  bandw_ff <= csr_data[4:0];
            REG_UPPER: upper_ff <= csr_data[0];
            REG_TRANS: trans_ff <= csr_data[0];
            REG_UNIT:  unit_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective n and k, clamped
   logic [CW-1:0] n_eff;
   logic [KW-1:0] k_eff;
   logic          forward;
   always_comb begin
      n_eff = (32'(size_ff) > MAX_N) ? CW'(MAX_N) : CW'(size_ff);
      k_eff = (32'(bandw_ff) > MAX_BAND) ? KW'(MAX_BAND) : KW'(bandw_ff);
      forward = (upper_ff == trans_ff);
   end

   // sequencer registers
   state_type state_ff, state_in;
   logic [CW-1:0] s_ff, s_in;              // solve step
   logic [NW-1:0] row_ff, row_in;
   logic [CW:0]   j_ff, j_in;              // current off-diagonal column
   logic [CW:0]   jend_ff, jend_in;
   logic signed [71:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] sum_ff, sum_in;     // saturated row sum
   logic signed [31:0] x_ff, x_in;         // row solution
   logic dz_ff, dz_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // RAM ports
   logic          b_we, v_we;
   logic [BW-1:0] b_wa, b_ra;
   logic [NW-1:0] v_wa, v_ra;
   logic [31:0]   b_wd, v_wd, b_rd, v_rd;

   bts_ram #(.WIDTH(32), .DEPTH(BD)) u_band (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   bts_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_vec (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));

   div_req_type div_req;
   div_rsp_type div_rsp;
   bts_div u_div (.clock, .reset, .req(div_req), .rsp(div_rsp));

   logic req_fire;
   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // band store address of column c, band position p
   function automatic logic [BW-1:0] band_addr(input logic [NW-1:0] c,
                                               input logic [KW-1:0] p);
      band_addr = BW'(c) * BW'(MAX_BAND + 1) + BW'(p);
   endfunction

   logic [NW-1:0] er, ec, jn;
   logic [KW-1:0] epos;
   logic [NW-1:0] row_next;
   logic [CW:0]   row_w, j0, j1;
   logic          slot_free;

   // Row engine:
   //  ST_ROW  : issue rhs read, set term range
   //  ST_RHS  : load rhs into acc, issue first term reads
   //  ST_TERM : multiply band entry by solved element
   //  ST_MUL  : accumulate, issue next term reads
   //  ST_DIAG : saturate sum, read diagonal
   //  ST_START: unit / zero diagonal, or launch divider
   //  ST_DIV  : wait divider
   //  ST_OUT  : load output register, write solution back
   always_comb begin
      state_in = state_ff; s_in = s_ff; row_in = row_ff; j_in = j_ff;
      jend_in = jend_ff; acc_in = acc_ff; prod_in = prod_ff; sum_in = sum_ff;
      x_in = x_ff; dz_in = dz_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      b_we = 1'b0; v_we = 1'b0;
      b_wa = band_addr(req_data.column[NW-1:0], req_data.band_pos[KW-1:0]);
      b_wd = req_data.value;
      v_wa = req_data.column[NW-1:0]; v_wd = req_data.value;
      div_req.start = 1'b0;
      div_req.dividend = 64'(sum_ff) <<< 16;
      div_req.divisor = b_rd;
      // term reads follow j_ff; transpose swaps row and column
      jn = j_ff[NW-1:0];
      er = trans_ff ? jn : row_ff;
      ec = trans_ff ? row_ff : jn;
      epos = upper_ff ? KW'(k_eff + KW'(er) - KW'(ec)) : KW'(er - ec);
      b_ra = band_addr(ec, epos);
      v_ra = jn;
      row_next = forward ? NW'(s_ff) : NW'(n_eff - CW'(1) - s_ff);
      row_w = (CW+1)'(row_next);
      j0 = (row_w >= (CW+1)'(k_eff)) ? row_w - (CW+1)'(k_eff) : '0;
      j1 = (row_w + (CW+1)'(k_eff) + (CW+1)'(1) < (CW+1)'(n_eff)) ?
           row_w + (CW+1)'(k_eff) + (CW+1)'(1) : (CW+1)'(n_eff);
      slot_free = !rsp_valid_ff || rsp_ready;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.op)
                  OP_BAND: b_we = (32'(req_data.column) < MAX_N) &&
                                  (32'(req_data.band_pos) <= MAX_BAND);
                  OP_RHS:  v_we = (32'(req_data.column) < MAX_N);
                  OP_SOLVE: begin
                     s_in = '0;
                     if (n_eff != '0) state_in = ST_ROW;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            row_in = row_next;
            if (forward) begin
               j_in = j0; jend_in = row_w;
            end else begin
               j_in = row_w + (CW+1)'(1); jend_in = j1;
            end
            v_ra = row_next;
            state_in = ST_RHS;
         end
         ST_RHS: begin
            acc_in = 72'($signed(v_rd));
            state_in = (j_ff < jend_ff) ? ST_TERM : ST_DIAG;
         end
         ST_TERM: begin
            prod_in = $signed(b_rd) * $signed(v_rd);
            j_in = j_ff + (CW+1)'(1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // floor to Q16.16, summed exactly
            acc_in = acc_ff - 72'(prod_ff >>> 16);
            state_in = (j_ff < jend_ff) ? ST_TERM : ST_DIAG;
         end
         ST_DIAG: begin
            sum_in = (acc_ff > ACC_MAX) ? 32'sh7FFF_FFFF :
                     (acc_ff < ACC_MIN) ? 32'sh8000_0000 : acc_ff[31:0];
            b_ra = band_addr(row_ff, upper_ff ? k_eff : '0);
            state_in = ST_START;
         end
         ST_START: begin
            dz_in = 1'b0;
            if (unit_ff) begin
               x_in = sum_ff;
               state_in = ST_OUT;
            end else if (b_rd == '0) begin
               // zero diagonal: saturate by the sign of the sum
               dz_in = 1'b1;
               x_in = sum_ff[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               state_in = ST_OUT;
            end else begin
               div_req.start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               x_in = div_rsp.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_in.index = row_ff;
               rsp_in.solution = x_ff;
               rsp_in.last = (s_ff + CW'(1) == n_eff);
               rsp_in.div_zero = dz_ff;
               rsp_valid_in = 1'b1;
               v_we = 1'b1; v_wa = row_ff; v_wd = x_ff;
               s_in = s_ff + CW'(1);
               state_in = (s_ff + CW'(1) == n_eff) ? ST_IDLE : ST_ROW;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff <= s_in; row_ff <= row_in; j_ff <= j_in; jend_ff <= jend_in;
      acc_ff <= acc_in; prod_ff <= prod_in; sum_ff <= sum_in;
      x_ff <= x_in; dz_ff <= dz_in; rsp_ff <= rsp_in;
   end

   `BTS_ASSERT_IMPL(a_busy, clock, reset, state_ff != ST_IDLE, !req_ready, "ready while busy")
   `BTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `BTS_ASSERT_NEXT(a_rsp_keep, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp moved")
   `BTS_ASSERT_IMPL(a_div_done, clock, reset, div_rsp.done, state_ff == ST_DIV, "stray divide")
endmodule
`default_nettype wire

// ===== sim/tb_banded_triangular_solve.sv =====
// Self-checking testbench for banded_triangular_solve: directed and random
// band loads and solves, checked against a behavioral predictor. Needs bts_pkg.
`timescale 1ns / 100ps
module tb_banded_triangular_solve;
   import bts_pkg::*;

   localparam int NMAX       = 64;
   localparam int KMAX       = 16;
   localparam int COL_STRIDE = KMAX + 1;
   localparam int DEPTH      = COL_STRIDE * NMAX;
   localparam int WD_LIMIT   = 20000;  // idle cycles
   localparam int SETTLE     = 300;    // covers a solve of size zero or a final row
   localparam int RAND_ITEMS = 60;
   localparam logic [1:0] OP_NONE = 2'd3;  // ignored opcode

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic       csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [6:0] csr_data = '0;

   // predictor state: band and vector stores plus which entries were loaded
   logic signed [31:0] band_mem [DEPTH];
   bit                 band_ok  [DEPTH];
   logic signed [31:0] vec_mem  [NMAX];
   bit                 vec_ok   [NMAX];
   int unsigned cfg_size = 1, cfg_band = 0;
   bit          cfg_upper = 0, cfg_trans = 0, cfg_unit = 0;

   rsp_type solution_q[$];   // expected solutions, oldest first
   int errors = 0;
   int loads_done = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int ready_hold = 0;

   banded_triangular_solve dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write, .csr_index, .csr_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // band store address of the effective element (row, j)
   function automatic int band_addr(int row, int j, int k);
      int r, c;
      r = cfg_trans ? j : row;
      c = cfg_trans ? row : j;
      return c * COL_STRIDE + (cfg_upper ? k + r - c : r - c);
   endfunction

   function automatic int eff_size();
      return (cfg_size > NMAX) ? NMAX : cfg_size;
   endfunction

   function automatic int eff_band();
      return (cfg_band > KMAX) ? KMAX : cfg_band;
   endfunction

   // substitution over the whole system; queues one solution per row
   function automatic void solve_system();
      int n, k, row, jlo, jhi;
      bit fwd;
      longint acc;
      logic signed [31:0] sum, x, d;
      rsp_type r;
      n = eff_size();
      k = eff_band();
      fwd = (cfg_upper == cfg_trans);
      for (int s = 0; s < n; s++) begin
         row = fwd ? s : n - 1 - s;
         acc = vec_mem[row];
         if (fwd) begin
            jlo = (row >= k) ? row - k : 0;
            jhi = row;
         end else begin
            jlo = row + 1;
            jhi = (row + k + 1 < n) ? row + k + 1 : n;
         end
         for (int j = jlo; j < jhi; j++)
            acc -= (longint'(band_mem[band_addr(row, j, k)]) * longint'(vec_mem[j])) >>> 16;
         sum = sat32(acc);
         x = sum;
         r.div_zero = 1'b0;
         if (!cfg_unit) begin
            d = band_mem[row * COL_STRIDE + (cfg_upper ? k : 0)];
            if (d == 0) begin
               r.div_zero = 1'b1;
               x = (sum >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
            end else begin
               x = sat32((longint'(sum) * 65536) / longint'(d));
            end
         end
         vec_mem[row] = x;
         r.index    = row[5:0];
         r.solution = x;
         r.last     = (s + 1 == n);
         solution_q.push_back(r);
      end
   endfunction

   function automatic void predict(req_type t);
      case (t.op)
         OP_BAND: if (t.band_pos <= KMAX) begin
            band_mem[t.column * COL_STRIDE + t.band_pos] = t.value;
            band_ok[t.column * COL_STRIDE + t.band_pos]  = 1'b1;
         end
         OP_RHS: begin
            vec_mem[t.column] = t.value;
            vec_ok[t.column]  = 1'b1;
         end
         OP_SOLVE: solve_system();
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   // mostly small Q16.16 values, now and then any 32-bit pattern
   function automatic logic signed [31:0] any_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
   endfunction

   // diagonal: magnitude 1.0..2.0, sometimes zero
   function automatic logic signed [31:0] diag_value();
      logic signed [31:0] m;
      if ($urandom_range(0, 9) == 0) return '0;
      m = $urandom_range(65536, 131072);
      return $urandom_range(0, 1) ? m : -m;
   endfunction

   // one transfer on req_*; valid stays up across a burst
   task automatic send(logic [1:0] op, logic [5:0] col, logic [4:0] pos,
                       logic signed [31:0] val);
      req_type t;
      t.op = op;
      t.column = col;
      t.band_pos = pos;
      t.value = val;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict(t);
      if (op != OP_NONE && !(op == OP_BAND && pos > KMAX)) loads_done++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   task automatic start_solve();
      send(OP_SOLVE, 6'($urandom), 5'($urandom), $urandom);
   endtask

   // wait for all solutions, then let any row still in flight finish
   task automatic drain();
      req_valid <= 1'b0;
      while (solution_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_put(logic [2:0] idx, logic [6:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
   endtask

   task automatic configure(int size, int band, bit upper, bit trans, bit unit);
      drain();
      csr_put(REG_SIZE, 7'(size));
      csr_put(REG_BAND, 7'(band));
      csr_put(REG_UPPER, 7'(upper));
      csr_put(REG_TRANS, 7'(trans));
      csr_put(REG_UNIT, 7'(unit));
      csr_write <= 1'b0;
      cfg_size  = size[6:0];
      cfg_band  = band[4:0];
      cfg_upper = upper;
      cfg_trans = trans;
      cfg_unit  = unit;
   endtask

   // load every entry the next solve reads that has never been written
   task automatic load_missing();
      int n, k, a, jlo, jhi;
      n = eff_size();
      k = eff_band();
      for (int row = 0; row < n; row++)
         if (!vec_ok[row]) send(OP_RHS, 6'(row), 5'($urandom), any_value());
      for (int row = 0; row < n; row++) begin
         if (!cfg_unit) begin
            a = row * COL_STRIDE + (cfg_upper ? k : 0);
            if (!band_ok[a]) send(OP_BAND, 6'(row), 5'(a % COL_STRIDE), diag_value());
         end
         if (cfg_upper == cfg_trans) begin
            jlo = (row >= k) ? row - k : 0;
            jhi = row;
         end else begin
            jlo = row + 1;
            jhi = (row + k + 1 < n) ? row + k + 1 : n;
         end
         for (int j = jlo; j < jhi; j++) begin
            a = band_addr(row, j, k);
            if (!band_ok[a])
               send(OP_BAND, 6'(a / COL_STRIDE), 5'(a % COL_STRIDE),
                    32'($signed($urandom_range(0, 65536)) - 32768));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // saturating values, zero diagonal, ignored writes and opcode
   task automatic test_extremes();
      configure(3, 1, 1'b0, 1'b0, 1'b0);
      send(OP_RHS, 6'd0, 5'd0, 32'sh7FFFFFFF);
      send(OP_RHS, 6'd1, 5'd0, 32'sh80000000);
      send(OP_RHS, 6'd2, 5'd0, 32'sh00018000);
      send(OP_BAND, 6'd0, 5'd0, 32'sh00010000);
      send(OP_BAND, 6'd1, 5'd0, 32'sh00000000);     // zero diagonal
      send(OP_BAND, 6'd2, 5'd0, 32'shFFFF0000);
      send(OP_BAND, 6'd0, 5'd1, 32'sh80000000);
      send(OP_BAND, 6'd1, 5'd1, 32'sh7FFFFFFF);
      send(OP_BAND, 6'd63, 5'd31, 32'sh12345678);   // position past the band: dropped
      send(OP_BAND, 6'd5, 5'd17, 32'shFFFFFFFF);    // dropped too
      send(OP_NONE, 6'd63, 5'd31, 32'shFFFFFFFF);   // ignored opcode
      send(OP_BAND, 6'd63, 5'(KMAX), 32'sh00020000);
      send(OP_RHS, 6'd63, 5'd31, 32'sh00000001);
      start_solve();
      // unit diagonal on the same data: sums saturate with no divide
      configure(3, 1, 1'b0, 1'b0, 1'b1);
      send(OP_RHS, 6'd0, 5'd0, 32'sh7FFFFFFF);
      send(OP_RHS, 6'd1, 5'd0, 32'sh80000000);
      start_solve();
   endtask

   // all four upper/transpose combinations, with and without unit diagonal
   task automatic test_orientations();
      for (int m = 0; m < 8; m++) begin
         configure($urandom_range(2, 6), $urandom_range(1, 3), m[0], m[1], m[2]);
         load_missing();
         start_solve();
      end
   endtask

   task automatic test_zero_size();
      configure(0, 2, 1'b0, 1'b0, 1'b0);
      start_solve();
   endtask

   // band width register above the band limit saturates: upper storage
   // puts the diagonal at the clamped position
   task automatic test_wide_band();
      configure(4, 31, 1'b1, 1'b0, 1'b0);
      load_missing();
      start_solve();
   endtask

   // size register above the limit: largest system, narrow band
   task automatic test_full_size();
      configure(127, 1, 1'b0, 1'b0, 1'b1);
      load_missing();
      start_solve();
   endtask

   task automatic test_random();
      int start_count;
      bit paused;
      start_count = loads_done;
      paused = 0;
      while (loads_done - start_count < RAND_ITEMS) begin
         configure($urandom_range(0, 7) == 0 ? $urandom_range(0, 24) : $urandom_range(1, 8),
                   $urandom_range(0, 20), 1'($urandom), 1'($urandom), 1'($urandom));
         repeat ($urandom_range(3, 12))
            send($urandom_range(0, 4) == 0 ? OP_NONE : 2'($urandom_range(0, 1)),
                 6'($urandom), 5'($urandom), any_value());
         load_missing();
         start_solve();
         // hold the sender off once until the block has answered everything
         if (!paused && loads_done - start_count > RAND_ITEMS / 2) begin
            paused = 1;
            req_valid <= 1'b0;
            while (solution_q.size() != 0) @(negedge clock);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Receiver stalls: held levels of random length
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready  <= $urandom_range(0, 2) != 0;
         ready_hold <= $urandom_range(0, 12);
      end
   end

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d", what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // Result checker and watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (solution_q.size() == 0) begin
               report("unexpected transfer index", rsp_data.index, -1);
            end else begin
               want = solution_q.pop_front();
               if (rsp_data.index != want.index)
                  report("index", rsp_data.index, want.index);
               if (rsp_data.solution != want.solution)
                  report("solution", rsp_data.solution, want.solution);
               if (rsp_data.last != want.last)
                  report("last", rsp_data.last, want.last);
               if (rsp_data.div_zero != want.div_zero)
                  report("div_zero", rsp_data.div_zero, want.div_zero);
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_orientations();
      test_zero_size();
      test_wide_band();
      test_full_size();
      test_random();
      drain();
      if (solution_q.size() != 0) report("solutions left over", solution_q.size(), 0);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
